>>> rtl/cfp_pkg.sv
// cfp_pkg: shared types, codes and helpers for the command frame parser.
// No dependencies; imported by every RTL and checker file of the block.
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned CountW  = 11;
  localparam int unsigned CmdW    = 3;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [7:0] EndByte  = 8'hF0;

  localparam logic [7:0] OpReadTime     = 8'h80;
  localparam logic [7:0] OpReadProfile  = 8'h81;
  localparam logic [7:0] OpWriteTime    = 8'h82;
  localparam logic [7:0] OpWriteProfile = 8'h83;
  localparam logic [7:0] OpTest         = 8'h84;
  localparam logic [7:0] OpTestError    = 8'h8F;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE         = 3'd0,
    CMD_READTIME     = 3'd1,
    CMD_READPROFILE  = 3'd2,
    CMD_WRITETIME    = 3'd3,
    CMD_WRITEPROFILE = 3'd4,
    CMD_TEST         = 3'd5,
    CMD_TESTERROR    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_TIME    = 2'd0,
    TGT_PROFILE = 2'd1,
    TGT_CRC     = 2'd2
  } tgt_e;

  typedef enum logic {
    ERR_UNKNOWN_CMD = 1'b0,
    ERR_MISSING_END = 1'b1
  } err_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [CountW-1:0] count;
  } state_t;

  typedef struct packed {
    logic              frame_done;
    logic [CmdW-1:0]   done_command;
    logic              error_flag;
    logic [CmdW-1:0]   error_command;
    logic              error_kind;
    logic              write_valid;
    logic [1:0]        write_target;
    logic [CountW-1:0] write_index;
    logic [7:0]        write_data;
  } result_t;

  function automatic logic [CmdW-1:0] decode_start(input logic [7:0] b);
    logic [CmdW-1:0] c;
    unique case (b)
      OpReadTime:     c = CMD_READTIME;
      OpReadProfile:  c = CMD_READPROFILE;
      OpWriteTime:    c = CMD_WRITETIME;
      OpWriteProfile: c = CMD_WRITEPROFILE;
      OpTest:         c = CMD_TEST;
      OpTestError:    c = CMD_TESTERROR;
      default:        c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/cfp_step.sv
// cfp_step: per-byte decision logic; next command/counter state and result.
// Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_step import cfp_pkg::*; #(
  parameter int unsigned TIME_BYTES    = 8,
  parameter int unsigned PROFILE_BYTES = 1440,
  parameter int unsigned CRC_BYTES     = 4
) (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  output state_t     state_o,
  output result_t    result_o
);

  localparam logic [CountW-1:0] TimeLim    = CountW'(TIME_BYTES);
  localparam logic [CountW-1:0] ProfileLim = CountW'(PROFILE_BYTES);
  localparam logic [CountW-1:0] PayloadLim = CountW'(PROFILE_BYTES + CRC_BYTES);

  logic [CmdW-1:0]   start_cmd;
  logic [CountW-1:0] count_inc;
  logic              idle;

  assign start_cmd = decode_start(byte_i);
  assign count_inc = (state_i.count == CountMax) ? state_i.count
                                                 : state_i.count + CountW'(1);
  // code 7 cannot arise but is treated as idle
  assign idle = (state_i.cmd == CMD_NONE) || (state_i.cmd > CMD_TESTERROR);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (idle) begin
      if (byte_i[7]) begin
        if (start_cmd != CMD_NONE) begin
          state_o.cmd = start_cmd;
          if (start_cmd == CMD_WRITETIME || start_cmd == CMD_WRITEPROFILE) begin
            state_o.count = '0;
          end
        end
      end else begin
        result_o.error_flag    = 1'b1;
        result_o.error_command = CMD_NONE;
        result_o.error_kind    = ERR_UNKNOWN_CMD;
      end
    end else if (state_i.cmd == CMD_WRITETIME && state_i.count < TimeLim) begin
      result_o.write_valid  = 1'b1;
      result_o.write_target = TGT_TIME;
      result_o.write_index  = state_i.count;
      result_o.write_data   = byte_i;
      state_o.count         = count_inc;
    end else if (state_i.cmd == CMD_WRITEPROFILE && state_i.count < ProfileLim) begin
      result_o.write_valid  = 1'b1;
      result_o.write_target = TGT_PROFILE;
      result_o.write_index  = state_i.count;
      result_o.write_data   = byte_i;
      state_o.count         = count_inc;
    end else if (state_i.cmd == CMD_WRITEPROFILE && state_i.count < PayloadLim) begin
      result_o.write_valid  = 1'b1;
      result_o.write_target = TGT_CRC;
      result_o.write_index  = state_i.count - ProfileLim;
      result_o.write_data   = byte_i;
      state_o.count         = count_inc;
    end else if (byte_i == EndByte) begin
      result_o.frame_done   = 1'b1;
      result_o.done_command = state_i.cmd;
      state_o.cmd           = CMD_NONE;
    end else begin
      // wrong end byte: flag it, keep command and counter
      result_o.error_flag    = 1'b1;
      result_o.error_command = state_i.cmd;
      result_o.error_kind    = ERR_MISSING_END;
    end
  end

endmodule

>>> rtl/command_frame_parser_unit.sv
// Command frame parser top level: input byte register, decision logic, result register.
// A byte goes into the input byte register; its result goes into the result register.
// Throughput: one byte per cycle; the input register and result register form a
//   two-stage pipeline that stalls only when a result waits and the next stage is full.
// Reset (rst_ni low, asynchronous): command returns to none, counter to 0, both stages empty.
// Depends on cfp_pkg and cfp_step.
`timescale 1ns / 1ps

module command_frame_parser_unit import cfp_pkg::*; #(
  parameter int unsigned TIME_BYTES    = 8,
  parameter int unsigned PROFILE_BYTES = 1440,
  parameter int unsigned CRC_BYTES     = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              frame_done_o,
  output logic [CmdW-1:0]   done_command_o,
  output logic              error_flag_o,
  output logic [CmdW-1:0]   error_command_o,
  output logic              error_kind_o,
  output logic              write_valid_o,
  output logic [1:0]        write_target_o,
  output logic [CountW-1:0] write_index_o,
  output logic [7:0]        write_data_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  state_t     state_q;
  state_t     state_d;
  logic       in_ready;
  logic       out_ready;
  logic       step_fire;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_ready  = !in_valid_q || out_ready;
  assign step_fire = in_valid_q && out_ready;
  assign in_stall_o = !in_ready;

  cfp_step #(
    .TIME_BYTES   (TIME_BYTES),
    .PROFILE_BYTES(PROFILE_BYTES),
    .CRC_BYTES    (CRC_BYTES)
  ) u_step (
    .state_i (state_q),
    .byte_i  (byte_q),
    .state_o (state_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (step_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = res_q.frame_done;
  assign done_command_o  = res_q.done_command;
  assign error_flag_o    = res_q.error_flag;
  assign error_command_o = res_q.error_command;
  assign error_kind_o    = res_q.error_kind;
  assign write_valid_o   = res_q.write_valid;
  assign write_target_o  = res_q.write_target;
  assign write_index_o   = res_q.write_index;
  assign write_data_o    = res_q.write_data;

endmodule

>>> rtl/cfp_checker.sv
// cfp_checker: port-level assertions for command_frame_parser_unit, plus its bind.
// Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_checker import cfp_pkg::*; #(
  parameter int unsigned TIME_BYTES    = 8,
  parameter int unsigned PROFILE_BYTES = 1440,
  parameter int unsigned CRC_BYTES     = 4
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              frame_done_o,
  input logic [CmdW-1:0]   done_command_o,
  input logic              error_flag_o,
  input logic              write_valid_o,
  input logic [1:0]        write_target_o,
  input logic [CountW-1:0] write_index_o,
  input logic [7:0]        write_data_o
);

  localparam logic [CountW-1:0] TimeLim    = CountW'(TIME_BYTES);
  localparam logic [CountW-1:0] ProfileLim = CountW'(PROFILE_BYTES);
  localparam logic [CountW-1:0] CrcLim     = CountW'(CRC_BYTES);

  // a held transfer keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_index_o)
      && $stable(write_data_o) && $stable(frame_done_o) && $stable(error_flag_o))
    else $error("result changed while stalled");

  // a byte is either a write, a completion, an error or nothing
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({frame_done_o, error_flag_o, write_valid_o}))
    else $error("more than one outcome for one byte");

  a_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> done_command_o != CMD_NONE)
    else $error("frame completed with no command");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |->
      (write_target_o == TGT_TIME && write_index_o < TimeLim) ||
      (write_target_o == TGT_PROFILE && write_index_o < ProfileLim) ||
      (write_target_o == TGT_CRC && write_index_o < CrcLim))
    else $error("write index out of range for its target");

endmodule

bind command_frame_parser_unit cfp_checker #(
  .TIME_BYTES   (TIME_BYTES),
  .PROFILE_BYTES(PROFILE_BYTES),
  .CRC_BYTES    (CRC_BYTES)
) u_cfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_done_o  (frame_done_o),
  .done_command_o(done_command_o),
  .error_flag_o  (error_flag_o),
  .write_valid_o (write_valid_o),
  .write_target_o(write_target_o),
  .write_index_o (write_index_o),
  .write_data_o  (write_data_o)
);
